// File: rtl/i2cbe_pkg.sv
// Package for the I2C master byte engine: payload structs, command kinds,
// sequencer phase codes and fixed byte-length constant. No dependencies.
package i2cbe_pkg;

  localparam int BitsPerByte = 8;

  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_START   = 3'd1;
  localparam logic [2:0] KIND_STOP    = 3'd2;
  localparam logic [2:0] KIND_RESTART = 3'd3;
  localparam logic [2:0] KIND_WRITE   = 3'd4;
  localparam logic [2:0] KIND_READ    = 3'd5;

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_ST_REL   = 4'd1;
  localparam logic [3:0] PH_ST_LOW   = 4'd2;
  localparam logic [3:0] PH_SP_LOW   = 4'd3;
  localparam logic [3:0] PH_SP_HIGH  = 4'd4;
  localparam logic [3:0] PH_SP_REL   = 4'd5;
  localparam logic [3:0] PH_BIT_LOW  = 4'd6;
  localparam logic [3:0] PH_BIT_HIGH = 4'd7;
  localparam logic [3:0] PH_ACK_LOW  = 4'd8;
  localparam logic [3:0] PH_ACK_HIGH = 4'd9;

  localparam logic CFG_LOW_TICKS  = 1'b0;
  localparam logic CFG_HIGH_TICKS = 1'b1;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_sample;
  } i2cbe_in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_seen;
    logic       command_rejected;
  } i2cbe_out_t;

  typedef struct packed {
    logic       is_cmd;
    logic [2:0] kind;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_sample;
  } i2cbe_op_t;

endpackage

// File: rtl/i2cbe_front.sv
// Front end: accepts input beats, classifies command vs. plain tick, and
// holds them in a two-entry queue for the sequencer. Uses i2cbe_pkg.
module i2cbe_front import i2cbe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  i2cbe_in_t in_data,
  output logic      q_valid,
  output i2cbe_op_t q_data,
  input  logic      q_pop
);

  i2cbe_op_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  i2cbe_op_t  op;

  always_comb begin
    op.kind       = in_data.kind;
    op.write_byte = in_data.write_byte;
    op.send_ack   = in_data.send_ack;
    op.sda_sample = in_data.sda_sample;
    unique case (in_data.kind) inside
      KIND_START, KIND_STOP, KIND_RESTART, KIND_WRITE, KIND_READ: op.is_cmd = 1'b1;
      default: op.is_cmd = 1'b0;
    endcase
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= op;
    end
  end

endmodule

// File: rtl/i2cbe_back.sv
// Back end: bus phase sequencer, timing registers and the result register.
// Takes classified beats from i2cbe_front; uses i2cbe_pkg.
module i2cbe_back import i2cbe_pkg::*; #(
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  i2cbe_op_t   q_data,
  output logic        q_pop,
  input  logic        cfg_we,
  input  logic        cfg_sel,
  input  logic [15:0] cfg_wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output i2cbe_out_t  out_data
);

  localparam int TW = TICK_COUNT_WIDTH;
  localparam logic [32:0] CntMax = (33'd1 << TW) - 33'd1;

  logic [15:0]   low_ticks_r, high_ticks_r;
  logic [3:0]    phase_r, phase_nxt;
  logic [2:0]    cmd_r, cmd_nxt;
  logic [TW-1:0] cnt_r, cnt_nxt;
  logic [3:0]    bit_r, bit_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic          ack_flag_r, ack_flag_nxt;
  logic          scl_r, scl_nxt;
  logic          sda_r, sda_nxt;
  logic          ack_choice_r, ack_choice_nxt;
  logic [7:0]    last_read_r, last_read_nxt;
  logic          out_valid_r;
  i2cbe_out_t    out_data_r;

  logic [15:0]   raw_len;
  logic [15:0]   lm1;
  logic [32:0]   lm1_w;
  logic [TW-1:0] lm1_sat;
  logic          last_tick;
  logic          started, rejected, done, do_enter;
  logic [3:0]    ent_p;
  logic [2:0]    cmd_cur;
  logic [7:0]    shift_mid;
  logic [3:0]    bit_mid;
  i2cbe_out_t    res;

  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  always_comb begin
    if (phase_r == PH_SP_LOW || phase_r == PH_BIT_LOW || phase_r == PH_ACK_LOW) begin
      raw_len = low_ticks_r;
    end else begin
      raw_len = high_ticks_r;
    end
    lm1       = (raw_len == 16'd0) ? 16'd0 : raw_len - 16'd1;
    lm1_w     = 33'(lm1);
    lm1_sat   = (lm1_w > CntMax) ? CntMax[TW-1:0] : lm1_w[TW-1:0];
    last_tick = (cnt_r >= lm1_sat);
  end

  always_comb begin
    phase_nxt      = phase_r;
    cmd_nxt        = cmd_r;
    cnt_nxt        = cnt_r;
    ack_flag_nxt   = ack_flag_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    ack_choice_nxt = ack_choice_r;
    last_read_nxt  = last_read_r;
    started        = 1'b0;
    rejected       = 1'b0;
    done           = 1'b0;
    do_enter       = 1'b0;
    ent_p          = PH_IDLE;
    shift_mid      = shift_r;
    bit_mid        = bit_r;

    if (q_data.is_cmd) begin
      if (phase_r != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        started  = 1'b1;
        cmd_nxt  = q_data.kind;
        bit_mid  = 4'd0;
        do_enter = 1'b1;
        unique case (q_data.kind) inside
          KIND_START: ent_p = PH_ST_REL;
          KIND_STOP, KIND_RESTART: ent_p = PH_SP_LOW;
          default: begin
            shift_mid      = (q_data.kind == KIND_WRITE) ? q_data.write_byte : 8'd0;
            ack_choice_nxt = q_data.send_ack;
            ent_p          = PH_BIT_LOW;
          end
        endcase
      end
    end

    cmd_cur = cmd_nxt;

    if (!started && phase_r != PH_IDLE) begin
      if (!last_tick) begin
        cnt_nxt = cnt_r + TW'(1);
      end else begin
        unique case (phase_r)
          PH_ST_LOW, PH_ACK_HIGH: done = 1'b1;
          PH_SP_REL: begin
            if (cmd_r == KIND_RESTART) begin
              do_enter = 1'b1;
              ent_p    = PH_ST_REL;
            end else begin
              done = 1'b1;
            end
          end
          PH_BIT_HIGH: begin
            bit_mid = bit_r + 4'd1;
            if (cmd_r == KIND_WRITE) begin
              shift_mid = {shift_r[6:0], 1'b0};
            end
            do_enter = 1'b1;
            if (bit_mid >= 4'(BitsPerByte)) begin
              if (cmd_r == KIND_READ) begin
                last_read_nxt = shift_mid;
              end
              ent_p = PH_ACK_LOW;
            end else begin
              ent_p = PH_BIT_LOW;
            end
          end
          default: begin
            do_enter = 1'b1;
            ent_p    = phase_r + 4'd1;
          end
        endcase
      end
    end

    bit_nxt   = bit_mid;
    shift_nxt = shift_mid;

    if (done) begin
      phase_nxt = PH_IDLE;
      cnt_nxt   = '0;
    end

    if (do_enter) begin
      phase_nxt = ent_p;
      cnt_nxt   = '0;
      unique case (ent_p)
        PH_ST_REL: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b0;
        end
        PH_ST_LOW, PH_SP_HIGH: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
        end
        PH_SP_LOW: begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b1;
        end
        PH_SP_REL: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b0;
        end
        PH_BIT_LOW: begin
          scl_nxt = 1'b0;
          sda_nxt = (cmd_cur == KIND_WRITE) ? ~shift_mid[7] : 1'b0;
        end
        PH_BIT_HIGH: begin
          scl_nxt = 1'b1;
          if (cmd_cur == KIND_READ) begin
            shift_nxt = {shift_mid[6:0], q_data.sda_sample};
          end
        end
        PH_ACK_LOW: begin
          scl_nxt = 1'b0;
          sda_nxt = (cmd_cur == KIND_READ) ? ack_choice_nxt : 1'b0;
        end
        PH_ACK_HIGH: begin
          scl_nxt = 1'b1;
          if (cmd_cur == KIND_WRITE) begin
            ack_flag_nxt = ~q_data.sda_sample;
          end
        end
        default: ;
      endcase
    end

    res.scl_level        = scl_nxt;
    res.sda_pull_low     = sda_nxt;
    res.busy_res         = (phase_nxt != PH_IDLE);
    res.done_res         = done;
    res.read_byte        = last_read_nxt;
    res.ack_seen         = ack_flag_nxt;
    res.command_rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_ticks_r  <= 16'd4;
      high_ticks_r <= 16'd5;
      phase_r      <= PH_IDLE;
      cmd_r        <= KIND_TICK;
      cnt_r        <= '0;
      bit_r        <= 4'd0;
      shift_r      <= 8'd0;
      ack_flag_r   <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b0;
      ack_choice_r <= 1'b0;
      last_read_r  <= 8'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_sel == CFG_LOW_TICKS) begin
          low_ticks_r <= cfg_wdata;
        end else begin
          high_ticks_r <= cfg_wdata;
        end
      end
      if (q_pop) begin
        phase_r      <= phase_nxt;
        cmd_r        <= cmd_nxt;
        cnt_r        <= cnt_nxt;
        bit_r        <= bit_nxt;
        shift_r      <= shift_nxt;
        ack_flag_r   <= ack_flag_nxt;
        scl_r        <= scl_nxt;
        sda_r        <= sda_nxt;
        ack_choice_r <= ack_choice_nxt;
        last_read_r  <= last_read_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_reject_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && rejected) |-> (phase_r != PH_IDLE))
    else $error("command rejected while sequencer idle");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= 4'(BitsPerByte))
    else $error("bit index past byte length");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (cnt_r == '0))
    else $error("tick count nonzero while idle");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid_r && (out_data_r.busy_res == (phase_r != PH_IDLE))))
    else $error("result register out of step with sequencer");
`endif

endmodule

// File: rtl/i2c_master_byte_engine_core.sv
// Top level of the I2C master byte engine: front queue plus bus sequencer.
// Depends on i2cbe_pkg, i2cbe_front and i2cbe_back.
//
//   port group  dir  handshake         payload
//   in_*        in   in_valid/in_stall  i2cbe_in_t  (kind, byte, ack choice, SDA)
//   out_*       out  out_valid/out_stall i2cbe_out_t (bus levels, status)
//   cfg_*       in   cfg_valid/cfg_ready index 0 low ticks, 1 high ticks
//
// One beat per clock while out_stall is low; an accepted beat is written into
// the queue, and is stepped and its result registered as it pops.
// The sequencer advances one phase tick per beat; the tick counter is the
// only loop. Synchronous active-low reset; config is always ready.
// Output stall backs up into the two-entry queue, then stalls the input.
module i2c_master_byte_engine_core import i2cbe_pkg::*; #(
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  i2cbe_in_t   in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output i2cbe_out_t  out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic      q_valid;
  logic      q_pop;
  i2cbe_op_t q_data;

  assign cfg_ready = 1'b1;

  i2cbe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  i2cbe_back #(
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_sel   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
